@@ src/sha1md_pkg.sv @@
package sha1md_pkg;

  typedef enum logic [1:0] {
    REQ_DATA    = 2'd0,
    REQ_FINISH  = 2'd1,
    REQ_RESTART = 2'd2
  } req_kind_t;

  typedef struct packed {
    req_kind_t   kind;
    logic [7:0]  data;
  } req_t;

  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  localparam logic [31:0] H_0 = 32'h67452301;
  localparam logic [31:0] H_1 = 32'hEFCDAB89;
  localparam logic [31:0] H_2 = 32'h98BADCFE;
  localparam logic [31:0] H_3 = 32'h10325476;
  localparam logic [31:0] H_4 = 32'hC3D2E1F0;

  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [6:0] LAST_ROUND  = 7'd79;
  localparam logic [4:0] LAST_DIGEST = 5'd19;
  localparam logic [5:0] LEN_START   = 6'd56;
  localparam logic [5:0] LAST_POS    = 6'd63;

  function automatic logic [31:0] round_k(input logic [6:0] r);
    if (r < 7'd20)      return K_0;
    else if (r < 7'd40) return K_1;
    else if (r < 7'd60) return K_2;
    else                return K_3;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    if (r < 7'd20)      return (b & c) | (~b & d);
    else if (r < 7'd40) return b ^ c ^ d;
    else if (r < 7'd60) return (b & c) | (b & d) | (c & d);
    else                return b ^ c ^ d;
  endfunction

endpackage

@@ src/sha1md_front.sv @@
module sha1md_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          req_type,
  input  logic [7:0]          data_byte,
  output logic                head_valid,
  output sha1md_pkg::req_t    head,
  input  logic                pop
);

  sha1md_pkg::req_t q [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             keep;
  logic             push;
  sha1md_pkg::req_t req;

  always_comb begin
    keep      = 1'b1;
    req.data  = data_byte;
    req.kind  = sha1md_pkg::REQ_DATA;
    unique case (req_type)
      sha1md_pkg::REQ_DATA:    req.kind = sha1md_pkg::REQ_DATA;
      sha1md_pkg::REQ_FINISH:  req.kind = sha1md_pkg::REQ_FINISH;
      sha1md_pkg::REQ_RESTART: req.kind = sha1md_pkg::REQ_RESTART;
      default:                 keep = 1'b0;
    endcase
  end

  assign in_stall   = (count == 2'd2);
  assign push       = in_valid && !in_stall && keep;
  assign head_valid = (count != 2'd0);
  assign head       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ src/sha1md_core.sv @@
module sha1md_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  sha1md_pkg::req_t    head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          digest_byte,
  output logic                status,
  output logic                last
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PAD   = 5'b00010,
    S_ROUND = 5'b00100,
    S_FOLD  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t         state;
  logic [31:0]    chain [5];
  logic [511:0]   window;
  logic [5:0]     pos;
  logic [63:0]    count;
  logic           finished;
  logic           broken;
  logic [31:0]    a, b, c, d, e;
  logic [6:0]     round;
  logic [4:0]     idx;
  logic           pad_active;
  logic           pad_first;
  logic           extra;
  logic           final_blk;

  logic           slot_free;
  logic [63:0]    count_next;
  logic [7:0]     pad_byte;
  logic           extra_eff;
  logic [31:0]    t_next;
  logic [31:0]    w_new;
  logic [31:0]    word;
  logic [7:0]     digest_sel;
  logic [63:0]    len_shift;
  logic [31:0]    word_shift;

  assign slot_free  = !out_valid || !out_stall;
  assign pop        = (state == S_IDLE) && head_valid && slot_free;
  assign count_next = count + 64'd8;
  assign extra_eff  = pad_first ? (pos >= sha1md_pkg::LEN_START) : extra;
  assign len_shift  = count >> {~pos[2:0], 3'b000};

  always_comb begin
    if (pad_first) begin
      pad_byte = sha1md_pkg::PAD_BYTE;
    end else if (pos >= sha1md_pkg::LEN_START && !extra) begin
      pad_byte = len_shift[7:0];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign t_next = {a[26:0], a[31:27]} + sha1md_pkg::round_f(round, b, c, d) + e
                + window[511:480] + sha1md_pkg::round_k(round);
  assign w_new  = {window[95:64] ^ window[255:224] ^ window[447:416] ^ window[511:480]};

  assign word       = chain[idx[4:2]];
  assign word_shift = word >> {~idx[1:0], 3'b000};
  assign digest_sel = word_shift[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      chain[0]   <= sha1md_pkg::H_0;
      chain[1]   <= sha1md_pkg::H_1;
      chain[2]   <= sha1md_pkg::H_2;
      chain[3]   <= sha1md_pkg::H_3;
      chain[4]   <= sha1md_pkg::H_4;
      pos        <= 6'd0;
      count      <= 64'd0;
      finished   <= 1'b0;
      broken     <= 1'b0;
      pad_active <= 1'b0;
      pad_first  <= 1'b0;
      extra      <= 1'b0;
      final_blk  <= 1'b0;
      round      <= 7'd0;
      idx        <= 5'd0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            case (head.kind)
              sha1md_pkg::REQ_DATA: begin
                out_valid   <= 1'b1;
                digest_byte <= 8'h00;
                last        <= 1'b1;
                if (finished) begin
                  broken <= 1'b1;
                  status <= 1'b1;
                end else if (broken) begin
                  status <= 1'b1;
                end else begin
                  status <= 1'b0;
                  window <= {window[503:0], head.data};
                  pos    <= pos + 6'd1;
                  count  <= count_next;
                  if (count_next == 64'd0) begin
                    broken <= 1'b1;
                  end
                  if (pos == sha1md_pkg::LAST_POS) begin
                    state     <= S_ROUND;
                    round     <= 7'd0;
                    final_blk <= 1'b0;
                    a <= chain[0];
                    b <= chain[1];
                    c <= chain[2];
                    d <= chain[3];
                    e <= chain[4];
                  end
                end
              end
              sha1md_pkg::REQ_FINISH: begin
                if (broken) begin
                  out_valid   <= 1'b1;
                  digest_byte <= 8'h00;
                  status      <= 1'b1;
                  last        <= 1'b1;
                end else if (finished) begin
                  idx   <= 5'd0;
                  state <= S_EMIT;
                end else begin
                  pad_active <= 1'b1;
                  pad_first  <= 1'b1;
                  extra      <= 1'b0;
                  state      <= S_PAD;
                end
              end
              sha1md_pkg::REQ_RESTART: begin
                chain[0] <= sha1md_pkg::H_0;
                chain[1] <= sha1md_pkg::H_1;
                chain[2] <= sha1md_pkg::H_2;
                chain[3] <= sha1md_pkg::H_3;
                chain[4] <= sha1md_pkg::H_4;
                pos      <= 6'd0;
                count    <= 64'd0;
                finished <= 1'b0;
                broken   <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_PAD: begin
          window    <= {window[503:0], pad_byte};
          pos       <= pos + 6'd1;
          pad_first <= 1'b0;
          extra     <= extra_eff;
          if (pos == sha1md_pkg::LAST_POS) begin
            state     <= S_ROUND;
            round     <= 7'd0;
            final_blk <= !extra_eff;
            extra     <= 1'b0;
            a <= chain[0];
            b <= chain[1];
            c <= chain[2];
            d <= chain[3];
            e <= chain[4];
          end
        end
        S_ROUND: begin
          a      <= t_next;
          b      <= a;
          c      <= {b[1:0], b[31:2]};
          d      <= c;
          e      <= d;
          window <= {window[479:0], w_new[30:0], w_new[31]};
          round  <= round + 7'd1;
          if (round == sha1md_pkg::LAST_ROUND) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
          chain[4] <= chain[4] + e;
          if (final_blk) begin
            finished   <= 1'b1;
            count      <= 64'd0;
            pad_active <= 1'b0;
            final_blk  <= 1'b0;
            idx        <= 5'd0;
            state      <= S_EMIT;
          end else if (pad_active) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid   <= 1'b1;
            digest_byte <= digest_sel;
            status      <= 1'b0;
            last        <= (idx == sha1md_pkg::LAST_DIGEST);
            idx         <= idx + 5'd1;
            if (idx == sha1md_pkg::LAST_DIGEST) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/sha1_message_digest.sv @@
// SHA-1 over a byte stream. A request is a data byte, a finish or a restart;
// requests pass through a two-entry queue to a sequencer that owns the
// 512-bit message window and the five-word chaining value. A data byte returns
// one status; every 64th byte also starts the compression, 80 rounds at one
// round per cycle followed by a fold of the result into the chaining value,
// during which later requests wait in the queue. A first finish shifts in
// the padding one byte per cycle, runs one or two compressions, then returns
// the 20 digest bytes at one per cycle while the output is not stalled, most
// significant byte first. A repeated finish returns the digest again. Restart
// returns nothing.
module sha1_message_digest (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] req_type,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] digest_byte,
  output logic       status,
  output logic       last
);

  logic             head_valid;
  sha1md_pkg::req_t head;
  logic             pop;

  sha1md_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .data_byte  (data_byte),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  sha1md_core u_core (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest_byte (digest_byte),
    .status      (status),
    .last        (last)
  );

  a_pop_has_head: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("request taken from empty queue");

  a_refusal_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> last)
    else $error("refusal not marked last");

  a_refusal_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> digest_byte == 8'h00)
    else $error("refusal carries nonzero byte");

endmodule

@@ bench/tb_top.sv @@
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct packed {
    logic [7:0] digest_byte;
    logic       status;
    logic       last;
  } digest_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] req_type = sha1md_pkg::REQ_DATA;
  logic [7:0] data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] digest_byte;
  logic       status;
  logic       last;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  digest_result_t pending_results[$];

  logic [31:0] hash_words[5];
  logic [7:0]  msg_block[64];
  logic [6:0]  fill_pos;
  logic [63:0] msg_bits;
  logic        digest_done;
  logic        corrupted;

  sha1_message_digest i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .digest_byte(digest_byte),
    .status(status),
    .last(last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic logic [31:0] rotl(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic clear_hash_state();
    hash_words[0] = sha1md_pkg::H_0;
    hash_words[1] = sha1md_pkg::H_1;
    hash_words[2] = sha1md_pkg::H_2;
    hash_words[3] = sha1md_pkg::H_3;
    hash_words[4] = sha1md_pkg::H_4;
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    fill_pos = '0;
    msg_bits = '0;
    digest_done = 1'b0;
    corrupted = 1'b0;
  endtask

  task automatic compress_message_block();
    logic [31:0] w[80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int r = 0; r < 16; r++)
      w[r] = {msg_block[r*4], msg_block[r*4+1], msg_block[r*4+2], msg_block[r*4+3]};
    for (int r = 16; r < 80; r++)
      w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
    a = hash_words[0];
    b = hash_words[1];
    c = hash_words[2];
    d = hash_words[3];
    e = hash_words[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A827999;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
      t = rotl(a, 5) + f + e + w[r] + k;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    hash_words[0] += a;
    hash_words[1] += b;
    hash_words[2] += c;
    hash_words[3] += d;
    hash_words[4] += e;
    fill_pos = '0;
  endtask

  task automatic pad_message();
    int p;
    p = fill_pos;
    msg_block[p] = 8'h80;
    p++;
    if (p > 56) begin
      while (p < 64) begin
        msg_block[p] = 8'h00;
        p++;
      end
      compress_message_block();
      p = 0;
    end
    while (p < 56) begin
      msg_block[p] = 8'h00;
      p++;
    end
    for (int i = 0; i < 8; i++) msg_block[56+i] = msg_bits[63-8*i -: 8];
    compress_message_block();
  endtask

  task automatic push_result(logic [7:0] db, logic st, logic lst);
    digest_result_t r;
    r.digest_byte = db;
    r.status = st;
    r.last = lst;
    pending_results.push_back(r);
  endtask

  task automatic predict_request(logic [1:0] kind, logic [7:0] b);
    case (kind)
      sha1md_pkg::REQ_DATA: begin
        if (digest_done) begin
          corrupted = 1'b1;
          push_result(8'h00, 1'b1, 1'b1);
        end else if (corrupted) begin
          push_result(8'h00, 1'b1, 1'b1);
        end else begin
          msg_block[fill_pos[5:0]] = b;
          fill_pos = fill_pos + 7'd1;
          msg_bits = msg_bits + 64'd8;
          if (msg_bits == 64'd0) corrupted = 1'b1;
          if (fill_pos == 7'd64) compress_message_block();
          push_result(8'h00, 1'b0, 1'b1);
        end
      end
      sha1md_pkg::REQ_FINISH: begin
        if (corrupted) begin
          push_result(8'h00, 1'b1, 1'b1);
        end else begin
          if (!digest_done) begin
            pad_message();
            for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
            msg_bits = '0;
            digest_done = 1'b1;
          end
          for (int i = 0; i < 20; i++)
            push_result(hash_words[i/4][31-8*(i%4) -: 8], 1'b0, i == 19);
        end
      end
      sha1md_pkg::REQ_RESTART: clear_hash_state();
      default: ;
    endcase
  endtask

  // hold the request until accepted; idle gaps come before it
  task automatic send_request(logic [1:0] kind, logic [7:0] b);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    data_byte <= b;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    predict_request(kind, b);
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_bytes(int n);
    for (int i = 0; i < n; i++) send_request(sha1md_pkg::REQ_DATA, 8'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    digest_result_t exp_r;
    if (out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: digest_byte %h status %b last %b",
                   digest_byte, status, last);
      end else begin
        exp_r = pending_results.pop_front();
        if (digest_byte !== exp_r.digest_byte || status !== exp_r.status ||
            last !== exp_r.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h/%b/%b actual %h/%b/%b",
                     exp_r.digest_byte, exp_r.status, exp_r.last,
                     digest_byte, status, last);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst && ((in_valid && !in_stall) || (out_valid && !out_stall)))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL sha1_message_digest");
      $finish;
    end
  end

  task automatic test_known_messages();
    send_request(sha1md_pkg::REQ_FINISH, 8'h00);
    send_request(sha1md_pkg::REQ_RESTART, 8'h00);
    send_request(sha1md_pkg::REQ_DATA, 8'h61);
    send_request(sha1md_pkg::REQ_DATA, 8'h62);
    send_request(sha1md_pkg::REQ_DATA, 8'h63);
    send_request(sha1md_pkg::REQ_DATA, 8'h00);
    send_request(sha1md_pkg::REQ_DATA, 8'hFF);
    send_request(sha1md_pkg::REQ_FINISH, 8'h00);
    send_request(sha1md_pkg::REQ_FINISH, 8'hFF);
  endtask

  task automatic test_refusals();
    send_request(sha1md_pkg::REQ_DATA, 8'hA5);
    send_request(sha1md_pkg::REQ_FINISH, 8'h00);
    send_request(sha1md_pkg::REQ_DATA, 8'h5A);
    send_request(REQ_UNUSED, 8'hFF);
    send_request(sha1md_pkg::REQ_RESTART, 8'hFF);
    send_request(REQ_UNUSED, 8'h00);
    send_request(sha1md_pkg::REQ_DATA, 8'h3C);
    send_request(sha1md_pkg::REQ_FINISH, 8'h00);
  endtask

  task automatic test_pad_boundaries();
    int sizes[2] = '{56, 63};
    foreach (sizes[i]) begin
      send_request(sha1md_pkg::REQ_RESTART, 8'h00);
      send_bytes(sizes[i]);
      send_request(sha1md_pkg::REQ_FINISH, 8'h00);
    end
  endtask

  task automatic test_random_traffic(int items);
    int sent;
    int n;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(9) == 0) begin
        send_request(2'($urandom_range(3)), 8'($urandom_range(255)));
        sent++;
      end else begin
        send_request(sha1md_pkg::REQ_RESTART, 8'($urandom_range(255)));
        n = ($urandom_range(7) == 0) ? $urandom_range(140) : $urandom_range(70);
        send_bytes(n);
        send_request(sha1md_pkg::REQ_FINISH, 8'($urandom_range(255)));
        sent += n + 2;
        if ($urandom_range(3) == 0) begin
          send_request(sha1md_pkg::REQ_FINISH, 8'h00);
          sent++;
        end
        if ($urandom_range(4) == 0) begin
          send_request(sha1md_pkg::REQ_DATA, 8'($urandom_range(255)));
          send_request(sha1md_pkg::REQ_FINISH, 8'h00);
          sent += 2;
        end
      end
    end
  endtask

  initial begin
    clear_hash_state();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_known_messages();
    test_refusals();
    test_pad_boundaries();

    send_idle_pct = 0;
    stall_pct = 0;
    test_random_traffic(24);
    send_idle_pct = 87;
    stall_pct = 0;
    test_random_traffic(24);
    send_idle_pct = 0;
    stall_pct = 87;
    test_random_traffic(24);
    send_idle_pct = 14;
    stall_pct = 14;
    test_random_traffic(24);

    drop_valid();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS sha1_message_digest");
    end else begin
      $display("FAIL sha1_message_digest");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
src/sha1md_pkg.sv
src/sha1md_front.sv
src/sha1md_core.sv
src/sha1_message_digest.sv
bench/tb_top.sv
